/* hw/rtl/dsiq_pkg.sv */
// Shared types and codes for the depth-sorted insert queue.
// Item and result structs, request and status codes, controller/datapath links.
// No dependencies.
`default_nettype none

package dsiq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_FULL   = 3'd3;
    localparam logic [2:0] OP_NOP    = 3'd4;
    localparam logic [2:0] OP_EMPTY  = 3'd5;
    localparam logic [2:0] OP_DRAIN  = 3'd6;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        entity_handle;
        logic signed [31:0] depth_key;
    } t_req_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_handle;
        logic signed [31:0] out_depth;
        logic [5:0]         position;
        logic [6:0]         entry_count;
        logic               last;
    } t_rsp_item;

    typedef struct packed {
        logic       load;
        logic [2:0] op;
    } t_dsiq_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       full;
        logic       empty;
        logic       drain_last;
        logic       out_free;
    } t_dsiq_sts;

endpackage

`default_nettype wire

/* hw/rtl/dsiq_ctrl.sv */
// Controller state machine for the depth-sorted insert queue.
// Sequences accept, insert, clear and drain steps; depends on dsiq_pkg.
`default_nettype none

module dsiq_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  dsiq_pkg::t_dsiq_sts  i_sts,
    output dsiq_pkg::t_dsiq_cmd  o_cmd
);
    import dsiq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                    case (i_sts.req_type)
                        REQ_PUSH: begin
                            o_cmd.op = i_sts.full ? OP_FULL : OP_INSERT;
                        end
                        REQ_CLEAR: begin
                            o_cmd.op = OP_CLEAR;
                        end
                        REQ_DRAIN: begin
                            if (i_sts.empty) begin
                                o_cmd.op = OP_EMPTY;
                            end else begin
                                o_cmd.op = OP_DRAIN;
                                if (!i_sts.drain_last) begin
                                    n_state = S_EXEC;
                                end
                            end
                        end
                        default: begin
                            o_cmd.op = OP_NOP;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/dsiq_dpath.sv */
// Datapath for the depth-sorted insert queue: entry row with parallel
// compare-and-shift insert, rotating drain, and the result register.
// Depends on dsiq_pkg.
`default_nettype none

module dsiq_dpath #(
    parameter int CAPACITY = dsiq_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_desc,
    input  dsiq_pkg::t_req_item  i_item,
    input  dsiq_pkg::t_dsiq_cmd  i_cmd,
    output dsiq_pkg::t_dsiq_sts  o_sts,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output dsiq_pkg::t_rsp_item  o_out_item
);
    import dsiq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [31:0]        r_hdl [CAPACITY];
    logic signed [31:0] r_key [CAPACITY];
    logic [31:0]        n_hdl [CAPACITY];
    logic signed [31:0] n_key [CAPACITY];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [IW-1:0]      r_pos;
    logic [IW-1:0]      n_pos;
    logic [CAPACITY-1:0] r_after;
    logic [CAPACITY-1:0] n_after;
    logic [CAPACITY-1:0] ge;
    t_req_item          r_req;
    t_req_item          n_req;
    t_rsp_item          r_out;
    t_rsp_item          n_out;
    logic               r_ovld;
    logic               n_ovld;
    logic               drain_last;

    assign drain_last = (CW'(r_pos) == (r_cnt - CW'(1)));

    assign o_sts.req_type   = r_req.req_type;
    assign o_sts.full       = (r_cnt == CW'(CAPACITY));
    assign o_sts.empty      = (r_cnt == '0);
    assign o_sts.drain_last = drain_last;
    assign o_sts.out_free   = !r_ovld || i_out_ready;

    always_comb begin
        ge = r_after;
        for (int s = 1; s < CAPACITY; s = s * 2) begin
            ge = ge | (ge << s);
        end
    end

    always_comb begin
        n_hdl   = r_hdl;
        n_key   = r_key;
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_after = r_after;
        n_req   = r_req;
        if (i_cmd.load) begin
            n_req = i_item;
            for (int i = 0; i < CAPACITY; i++) begin
                if (CW'(i) < r_cnt) begin
                    n_after[i] = i_desc ? (r_key[i] < i_item.depth_key)
                                        : (r_key[i] > i_item.depth_key);
                end else begin
                    n_after[i] = (CW'(i) == r_cnt);
                end
            end
        end
        case (i_cmd.op)
            OP_INSERT: begin
                if (ge[0]) begin
                    n_hdl[0] = r_req.entity_handle;
                    n_key[0] = r_req.depth_key;
                end
                for (int i = 1; i < CAPACITY; i++) begin
                    if (ge[i]) begin
                        if (ge[i-1]) begin
                            n_hdl[i] = r_hdl[i-1];
                            n_key[i] = r_key[i-1];
                        end else begin
                            n_hdl[i] = r_req.entity_handle;
                            n_key[i] = r_req.depth_key;
                        end
                    end
                end
                n_cnt = r_cnt + CW'(1);
            end
            OP_CLEAR: begin
                n_cnt = '0;
            end
            OP_DRAIN: begin
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (CW'(i + 1) < r_cnt) begin
                        n_hdl[i] = r_hdl[i+1];
                        n_key[i] = r_key[i+1];
                    end else begin
                        n_hdl[i] = r_hdl[0];
                        n_key[i] = r_key[0];
                    end
                end
                n_hdl[CAPACITY-1] = r_hdl[0];
                n_key[CAPACITY-1] = r_key[0];
                n_pos = drain_last ? '0 : r_pos + IW'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out             = r_out;
        n_ovld            = r_ovld && !i_out_ready;
        n_out.status      = ST_OK;
        n_out.out_handle  = '0;
        n_out.out_depth   = '0;
        n_out.position    = '0;
        n_out.entry_count = 7'(r_cnt);
        n_out.last        = 1'b1;
        case (i_cmd.op)
            OP_NONE: begin
                n_out = r_out;
            end
            OP_INSERT: begin
                n_ovld            = 1'b1;
                n_out.entry_count = 7'(r_cnt + CW'(1));
            end
            OP_CLEAR: begin
                n_ovld            = 1'b1;
                n_out.entry_count = '0;
            end
            OP_FULL: begin
                n_ovld       = 1'b1;
                n_out.status = ST_FULL;
            end
            OP_EMPTY: begin
                n_ovld       = 1'b1;
                n_out.status = ST_EMPTY;
            end
            OP_DRAIN: begin
                n_ovld           = 1'b1;
                n_out.out_handle = r_hdl[0];
                n_out.out_depth  = r_key[0];
                n_out.position   = 6'(r_pos);
                n_out.last       = drain_last;
            end
            default: begin
                n_ovld = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_hdl   <= n_hdl;
        r_key   <= n_key;
        r_after <= n_after;
        r_req   <= n_req;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pos  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_pos  <= n_pos;
            r_ovld <= n_ovld;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

/* hw/rtl/depth_sorted_insert_queue.sv */
// Depth-sorted insert queue: one item in work at a time; output hold-off adds stall cycles.
// Push, clear and unused codes: compare registered at accept, then shift and result once the
// output is free. Drain: first result after the compare, then one entry per cycle from the
// rotating entry row while the output is free; next item accepted after the last entry.
// Reset empties the list and selects ascending order; entry contents stay undefined.
// Depends on dsiq_pkg, dsiq_ctrl and dsiq_dpath.
`default_nettype none

module depth_sorted_insert_queue #(
    parameter int CAPACITY = dsiq_pkg::CAPACITY_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  dsiq_pkg::t_req_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output dsiq_pkg::t_rsp_item  o_out_item,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [2:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import dsiq_pkg::*;

    localparam logic [2:0] ADDR_SORT_DESC = 3'd0;

    logic      r_sort_desc;
    t_dsiq_cmd cmd;
    t_dsiq_sts sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SORT_DESC) ? {31'd0, r_sort_desc} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_desc <= 1'b0;
        end else if (psel && penable && pwrite && (paddr == ADDR_SORT_DESC)) begin
            r_sort_desc <= pwdata[0];
        end
    end

    dsiq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dsiq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (r_sort_desc),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.entry_count <= 7'(CAPACITY)))
        else $error("entry count above capacity");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status == ST_FULL))
        |-> ((o_out_item.entry_count == 7'(CAPACITY)) && o_out_item.last))
        else $error("full drop with list not full");

    a_drain_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last)
        |-> ((o_out_item.status == ST_OK)
             && ((7'(o_out_item.position) + 7'd1) < o_out_item.entry_count)))
        else $error("non-final result outside drain range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while previous item still in work");
`endif

endmodule

`default_nettype wire

/* tb/dsiq_checker.sv */
// Result checker for the depth-sorted insert queue: keeps its own sorted entry list,
// follows the sort-direction register, and compares every result field by field.
// Depends on dsiq_pkg.

module dsiq_checker
    import dsiq_pkg::*;
#(
    parameter int         CAPACITY      = CAPACITY_DEF,
    parameter logic [2:0] SORT_DIR_ADDR = 3'd0
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    input  wire         i_in_ready,
    input  t_req_item   i_in_item,
    input  wire         i_out_valid,
    input  wire         i_out_ready,
    input  t_rsp_item   i_out_item,
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire         i_pready,
    input  wire [2:0]   i_paddr,
    input  wire [31:0]  i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0]        slot_handle [CAPACITY];
    logic signed [31:0] slot_depth  [CAPACITY];
    int                 held = 0;
    logic               descending = 1'b0;
    t_rsp_item          expected_rsps [$];
    int                 fails = 0;

    function automatic void expect_rsp(logic [1:0] st, logic [31:0] handle,
                                       logic signed [31:0] depth, int pos, int cnt,
                                       bit is_last);
        t_rsp_item r;
        r.status      = st;
        r.out_handle  = handle;
        r.out_depth   = depth;
        r.position    = 6'(pos);
        r.entry_count = 7'(cnt);
        r.last        = is_last;
        expected_rsps = {expected_rsps, r};
    endfunction

    function automatic void insert_entry(logic [31:0] handle, logic signed [31:0] depth);
        int  at;
        bit  found;
        at = held;
        found = 1'b0;
        for (int i = 0; i < held; i++) begin
            if (!found && (descending ? (slot_depth[i] < depth) : (slot_depth[i] > depth))) begin
                at = i;
                found = 1'b1;
            end
        end
        for (int i = held; i > at; i--) begin
            slot_handle[i] = slot_handle[i - 1];
            slot_depth[i]  = slot_depth[i - 1];
        end
        slot_handle[at] = handle;
        slot_depth[at]  = depth;
        held++;
    endfunction

    function automatic void predict(t_req_item it);
        case (it.req_type)
            REQ_PUSH: begin
                if (held >= CAPACITY) begin
                    expect_rsp(ST_FULL, '0, '0, 0, held, 1'b1);
                end else begin
                    insert_entry(it.entity_handle, it.depth_key);
                    expect_rsp(ST_OK, '0, '0, 0, held, 1'b1);
                end
            end
            REQ_CLEAR: begin
                held = 0;
                expect_rsp(ST_OK, '0, '0, 0, 0, 1'b1);
            end
            REQ_DRAIN: begin
                if (held == 0) begin
                    expect_rsp(ST_EMPTY, '0, '0, 0, 0, 1'b1);
                end else begin
                    for (int i = 0; i < held; i++)
                        expect_rsp(ST_OK, slot_handle[i], slot_depth[i], i, held,
                                   i == held - 1);
                end
            end
            default: begin
                expect_rsp(ST_OK, '0, '0, 0, held, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp_item want;
        if (!i_rst_n) begin
            held = 0;
            descending = 1'b0;
            expected_rsps.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("result with no expectation waiting");
                    fails++;
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("status", want.status, i_out_item.status);
                    check_field("out_handle", want.out_handle, i_out_item.out_handle);
                    check_field("out_depth", want.out_depth, i_out_item.out_depth);
                    check_field("position", want.position, i_out_item.position);
                    check_field("entry_count", want.entry_count, i_out_item.entry_count);
                    check_field("last", want.last, i_out_item.last);
                end
            end
            if (i_in_valid && i_in_ready)
                predict(i_in_item);
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == SORT_DIR_ADDR)
                descending = i_pwdata[0];
        end
        o_pending = expected_rsps.size();
        o_fail_count = fails;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the depth-sorted insert queue: clock, reset, request stimulus,
// result-side stalls and register writes, with the verdict taken from dsiq_checker.
// Depends on dsiq_pkg, depth_sorted_insert_queue and dsiq_checker.

module tb;
    import dsiq_pkg::*;

    localparam logic [2:0] SORT_DIR_ADDR   = 3'd0;
    localparam logic [1:0] REQ_UNUSED      = 2'd3;
    localparam bit         SORT_ASCENDING  = 1'b0;
    localparam bit         SORT_DESCENDING = 1'b1;
    localparam int         CYCLE_LIMIT     = 1000000;
    localparam int         HOLD_OFF_CYCLES = 150;
    localparam int         PRESSURE_AT     = 160;
    localparam int         TAIL_CYCLES     = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_req_item   req_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_rsp_item   rsp_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          sent_count = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;

    depth_sorted_insert_queue #(.CAPACITY(CAPACITY_DEF)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (req_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (rsp_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    dsiq_checker #(.CAPACITY(CAPACITY_DEF), .SORT_DIR_ADDR(SORT_DIR_ADDR)) order_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (req_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (rsp_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb failed");
        $finish;
    end

    // result side: random short stalls, one long hold-off to back up the queue
    initial begin
        int  low_left;
        int  hold_left;
        bit  pressure_done;
        low_left = 0;
        hold_left = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge clk);
            if (!pressure_done && sent_count >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (low_left > 0) begin
                out_ready <= 1'b0;
                low_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                low_left = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_request(logic [1:0] req, logic [31:0] handle,
                                logic signed [31:0] depth);
        t_req_item it;
        int        gap;
        it.req_type      = req;
        it.entity_handle = handle;
        it.depth_key     = depth;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        req_item <= it;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_sort_dir(bit dir);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SORT_DIR_ADDR;
        pwdata  <= {31'd0, dir};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // favor a few whole-unit keys so ties are common
    function automatic logic signed [31:0] pick_depth();
        case ($urandom_range(0, 3))
            0, 1: return {16'($urandom_range(0, 4)) - 16'd2, 16'h0000};
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic push_burst(int count);
        repeat (count) send_request(REQ_PUSH, $urandom, pick_depth());
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            if ($urandom_range(0, 1))
                send_request(REQ_CLEAR, $urandom, $urandom);
            push_burst($urandom_range(1, 12));
            send_request(REQ_DRAIN, $urandom, $urandom);
        end else if (pick == 7) begin
            send_request(REQ_DRAIN, $urandom, $urandom);
        end else if (pick == 8) begin
            send_request($urandom_range(0, 1) ? REQ_CLEAR : REQ_UNUSED, $urandom, $urandom);
        end else begin
            push_burst(1);
        end
    endtask

    task automatic run_random_phase(int item_count, bit dir);
        int stop_at;
        wait_idle();
        write_sort_dir(dir);
        stop_at = sent_count + item_count;
        while (sent_count < stop_at) random_sequence();
    endtask

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        write_sort_dir(SORT_ASCENDING);
        send_request(REQ_DRAIN, 32'h0, 32'sh0);
        send_request(REQ_PUSH, 32'h0000_0000, 32'sh0000_0000);
        send_request(REQ_PUSH, 32'hffff_ffff, 32'sh7fff_ffff);
        send_request(REQ_PUSH, 32'h0000_0001, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'h0000_0002, 32'sh0000_0000);
        send_request(REQ_PUSH, 32'h0000_0003, -32'sd1);
        send_request(REQ_PUSH, 32'haaaa_aaaa, 32'sh0001_0000);
        send_request(REQ_UNUSED, 32'h5555_5555, 32'sh5555_5555);
        send_request(REQ_DRAIN, 32'hffff_ffff, -32'sd1);
        send_request(REQ_CLEAR, 32'h0, 32'sh0);
        send_request(REQ_DRAIN, 32'h0, 32'sh0);
        send_request(REQ_CLEAR, 32'h0, 32'sh0);
        send_request(REQ_PUSH, 32'h0000_0010, 32'sh0001_0000);
        send_request(REQ_PUSH, 32'h0000_0011, 32'sh0002_0000);
        send_request(REQ_PUSH, 32'h0000_0012, -32'sh0003_0000);

        // flip direction with entries still held
        wait_idle();
        write_sort_dir(SORT_DESCENDING);
        send_request(REQ_PUSH, 32'h0000_0020, 32'sh0000_0000);
        send_request(REQ_PUSH, 32'h0000_0021, 32'sh0002_0000);
        send_request(REQ_PUSH, 32'h0000_0022, 32'sh8000_0000);
        send_request(REQ_PUSH, 32'h0000_0023, 32'sh7fff_ffff);
        send_request(REQ_DRAIN, 32'h0, 32'sh0);

        run_random_phase(60, SORT_DESCENDING);
        run_random_phase(40, SORT_ASCENDING);

        // fill past capacity, then read the full list out
        send_request(REQ_CLEAR, $urandom, $urandom);
        push_burst(CAPACITY_DEF + 2);
        send_request(REQ_DRAIN, $urandom, $urandom);

        run_random_phase(50, 1'($urandom_range(0, 1)));

        wait_idle();
        quiet = 1'b1;
        run_random_phase(30, SORT_DESCENDING);

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/dsiq_pkg.sv
hw/rtl/dsiq_ctrl.sv
hw/rtl/dsiq_dpath.sv
hw/rtl/depth_sorted_insert_queue.sv
tb/dsiq_checker.sv
tb/tb.sv
